### rtl/lpg_pkg.sv
package lpg_pkg;

   localparam int PIX_BITS = 16;

   // request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [PIX_BITS-1:0] x_start;
      logic [PIX_BITS-1:0] y_start;
      logic [PIX_BITS-1:0] x_end;
      logic [PIX_BITS-1:0] y_end;
      logic [PIX_BITS-1:0] pixel_color_in;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_x;
      logic [PIX_BITS-1:0] pixel_y;
      logic [PIX_BITS-1:0] pixel_color;
      logic                last_pixel;
   } rsp_type;

   // stepping direction of a line
   typedef struct packed {
      logic x_is_major;
      logic x_step_negative;
      logic y_step_negative;
   } step_dir_type;

endpackage

### rtl/lpg_setup.sv
module lpg_setup #(
   parameter int CW = 16
) (
   input  logic [CW-1:0]        x_start,
   input  logic [CW-1:0]        y_start,
   input  logic [CW-1:0]        x_end,
   input  logic [CW-1:0]        y_end,
   output lpg_pkg::step_dir_type dir,
   output logic [CW-1:0]        major,
   output logic [CW:0]          twice_major,
   output logic [CW:0]          twice_minor,
   output logic signed [CW+2:0] err_init
);

   logic [CW:0]   dx;
   logic [CW:0]   dy;
   logic [CW:0]   dx_neg;
   logic [CW:0]   dy_neg;
   logic [CW-1:0] adx;
   logic [CW-1:0] ady;
   logic [CW-1:0] minor;

   always_comb begin
      dx = {1'b0, x_end} - {1'b0, x_start};
      dy = {1'b0, y_end} - {1'b0, y_start};
      dx_neg = -dx;
      dy_neg = -dy;
      // magnitudes never exceed 2^CW-1, so the low CW bits hold them
      adx = dx[CW] ? dx_neg[CW-1:0] : dx[CW-1:0];
      ady = dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];
      dir.x_step_negative = dx[CW];
      dir.y_step_negative = dy[CW];
      dir.x_is_major = adx > ady;   // ties step along y
      major = dir.x_is_major ? adx : ady;
      minor = dir.x_is_major ? ady : adx;
      twice_major = {major, 1'b0};
      twice_minor = {minor, 1'b0};
      err_init = signed'({2'b00, minor, 1'b0}) - signed'({3'b000, major});
   end

endmodule

### rtl/lpg_step.sv
module lpg_step #(
   parameter int CW = 16
) (
   input  logic [CW-1:0]         cur_x,
   input  logic [CW-1:0]         cur_y,
   input  logic signed [CW+2:0]  err,
   input  logic [CW:0]           twice_major,
   input  logic [CW:0]           twice_minor,
   input  lpg_pkg::step_dir_type dir,
   output logic [CW-1:0]         next_x,
   output logic [CW-1:0]         next_y,
   output logic signed [CW+2:0]  next_err
);

   logic          minor_step;
   logic          step_x;
   logic          step_y;
   logic [CW-1:0] x_moved;
   logic [CW-1:0] y_moved;

   always_comb begin
      minor_step = ~err[CW+2];
      step_x = dir.x_is_major | minor_step;
      step_y = ~dir.x_is_major | minor_step;
      x_moved = dir.x_step_negative ? cur_x - 1'b1 : cur_x + 1'b1;
      y_moved = dir.y_step_negative ? cur_y - 1'b1 : cur_y + 1'b1;
      next_x = step_x ? x_moved : cur_x;
      next_y = step_y ? y_moved : cur_y;
      next_err = err + signed'({2'b00, twice_minor})
                 - (minor_step ? signed'({2'b00, twice_major}) : '0);
   end

endmodule

### rtl/line_pixel_generator.sv
// Channel  Direction  Payload            Handshake
// req      in         lpg_pkg::req_type  req_valid / req_stall
// rsp      out        lpg_pkg::rsp_type  rsp_valid / rsp_stall
//
// One transaction per cycle unless rsp stalls: a start or next request is
// resolved in the cycle it is accepted and its pixel sits in the rsp register
// the next cycle. The line setup and one Bresenham step feed the state
// registers combinationally. Synchronous reset leaves the block idle with rsp
// empty. req stalls only while a held pixel is stalled on rsp.
module line_pixel_generator #(
   parameter int COORD_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpg_pkg::rsp_type rsp_data
);

   localparam int CW = COORD_BITS;
   localparam int PB = lpg_pkg::PIX_BITS;

   logic                  active_ff, active_in;
   logic [CW-1:0]         cur_x_ff, cur_x_in;
   logic [CW-1:0]         cur_y_ff, cur_y_in;
   logic signed [CW+2:0]  err_ff, err_in;
   logic [CW-1:0]         left_ff, left_in;
   logic [CW:0]           tmaj_ff, tmaj_in;
   logic [CW:0]           tmin_ff, tmin_in;
   lpg_pkg::step_dir_type dir_ff, dir_in;
   logic [PB-1:0]         color_ff, color_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lpg_pkg::rsp_type      rsp_ff, rsp_in;

   lpg_pkg::step_dir_type s_dir;
   logic [CW-1:0]         s_major;
   logic [CW:0]           s_tmaj;
   logic [CW:0]           s_tmin;
   logic signed [CW+2:0]  s_err;

   logic [CW-1:0]         st_x, st_y, nx_x, nx_y;
   logic signed [CW+2:0]  st_err, nx_err;
   logic [CW:0]           st_tmaj, st_tmin;
   lpg_pkg::step_dir_type st_dir;

   logic                  accept;
   logic                  is_start;
   logic [CW-1:0]         xs, ys;
   logic [CW-1:0]         left_dec;

   assign xs = req_data.x_start[CW-1:0];
   assign ys = req_data.y_start[CW-1:0];

   lpg_setup #(.CW(CW)) u_setup (
      .x_start     (xs),
      .y_start     (ys),
      .x_end       (req_data.x_end[CW-1:0]),
      .y_end       (req_data.y_end[CW-1:0]),
      .dir         (s_dir),
      .major       (s_major),
      .twice_major (s_tmaj),
      .twice_minor (s_tmin),
      .err_init    (s_err)
   );

   // a start steps off the freshly set up line, a next off the stored one
   always_comb begin
      if (is_start) begin
         st_x = xs;
         st_y = ys;
         st_err = s_err;
         st_tmaj = s_tmaj;
         st_tmin = s_tmin;
         st_dir = s_dir;
      end else begin
         st_x = cur_x_ff;
         st_y = cur_y_ff;
         st_err = err_ff;
         st_tmaj = tmaj_ff;
         st_tmin = tmin_ff;
         st_dir = dir_ff;
      end
   end

   lpg_step #(.CW(CW)) u_step (
      .cur_x       (st_x),
      .cur_y       (st_y),
      .err         (st_err),
      .twice_major (st_tmaj),
      .twice_minor (st_tmin),
      .dir         (st_dir),
      .next_x      (nx_x),
      .next_y      (nx_y),
      .next_err    (nx_err)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;
   assign is_start = req_data.opcode == lpg_pkg::OP_START;
   assign left_dec = left_ff - 1'b1;

   always_comb begin
      active_in = active_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      err_in = err_ff;
      left_in = left_ff;
      tmaj_in = tmaj_ff;
      tmin_in = tmin_ff;
      dir_in = dir_ff;
      color_in = color_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (accept && is_start) begin
         rsp_valid_in = 1'b1;
         rsp_in.pixel_x = PB'(xs);
         rsp_in.pixel_y = PB'(ys);
         rsp_in.pixel_color = req_data.pixel_color_in;
         rsp_in.last_pixel = s_major == '0;
         active_in = s_major != '0;
         left_in = s_major;
         tmaj_in = s_tmaj;
         tmin_in = s_tmin;
         dir_in = s_dir;
         color_in = req_data.pixel_color_in;
         cur_x_in = nx_x;
         cur_y_in = nx_y;
         err_in = nx_err;
      end else if (accept && active_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in.pixel_x = PB'(cur_x_ff);
         rsp_in.pixel_y = PB'(cur_y_ff);
         rsp_in.pixel_color = color_ff;
         rsp_in.last_pixel = left_dec == '0;
         left_in = left_dec;
         if (left_dec == '0) begin
            active_in = 1'b0;
         end else begin
            cur_x_in = nx_x;
            cur_y_in = nx_y;
            err_in = nx_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      err_ff <= err_in;
      left_ff <= left_in;
      tmaj_ff <= tmaj_in;
      tmin_ff <= tmin_in;
      dir_ff <= dir_in;
      color_ff <= color_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
